// ===== rtl/sbrp_pkg.sv =====
// Shared types, constants and helpers for the session backoff and renewal policy.
`timescale 1ns / 1ps

package sbrp_pkg;

	localparam int TIME_BITS = 48;
	localparam int CFG_BITS  = 32;
	localparam int FAIL_BITS = 10;
	localparam logic [FAIL_BITS-1:0] FAIL_CAP = FAIL_BITS'(1000);

	typedef enum logic [1:0] {
		OP_OPENED = 2'd0,
		OP_CLOSED = 2'd1,
		OP_POLL   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_WAIT    = 3'd1,
		ACT_CONNECT = 3'd2,
		ACT_KEEP    = 3'd3,
		ACT_RENEW   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		CFG_MAX_SESSION_TIME = 2'd0,
		CFG_RENEW_MARGIN     = 2'd1,
		CFG_BACKOFF_START    = 2'd2,
		CFG_BACKOFF_LIMIT    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		op_t                  operation;
		logic [TIME_BITS-1:0] now_time;
		logic                 close_failed;
		logic                 request_busy;
		logic                 link_up;
	} in_word_t;

	typedef struct packed {
		action_t              action;
		logic [FAIL_BITS-1:0] failure_count;
		logic                 session_open;
	} out_word_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] max_session_time;
		logic [CFG_BITS-1:0] renew_margin;
		logic [CFG_BITS-1:0] backoff_start;
		logic [CFG_BITS-1:0] backoff_limit;
	} cfg_t;

	typedef struct packed {
		logic                load;
		logic [CFG_BITS-1:0] value;
	} bo_load_t;

	// Add a time and an interval, clamping at the top of the time range.
	function automatic logic [TIME_BITS-1:0] time_add_sat(
		input logic [TIME_BITS-1:0] a,
		input logic [CFG_BITS-1:0]  b
	);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, a} + {{(TIME_BITS + 1 - CFG_BITS){1'b0}}, b};
		return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
	endfunction

endpackage

// ===== rtl/session_backoff_renew_policy_top.sv =====
// Top level of the session backoff and renewal policy block.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid, in_ready, in_word          | event words in
//   out     | out_valid, out_ready, out_word       | one result word per event
//   cfg     | cfg_valid, cfg_ready, cfg_index/data | register writes in
//
// An event word goes into the input stage register, is decided combinationally
// against the session registers and lands in the output register; one word per
// cycle is sustained while the output is not stalled. The input stage moves on
// whenever the output register is empty or being drained, so a full output
// register stalls only the input stage behind it. Reset clears the session
// state and the configuration registers; the register port is always ready.
`timescale 1ns / 1ps

module session_backoff_renew_policy_top import sbrp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_word_t            in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output out_word_t           out_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cfg_idx_t            cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	logic      item_valid_s1;
	in_word_t  item_s1;
	logic      out_valid_q;
	out_word_t out_word_q;
	logic      advance;
	cfg_t      cfg;
	bo_load_t  bo_load;
	out_word_t result;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !item_valid_s1 || advance;

	sbrp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.bo_load  (bo_load)
	);

	sbrp_policy u_policy (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.bo_load (bo_load),
		.fire    (item_valid_s1 && advance),
		.item    (item_s1),
		.result  (result)
	);

	// Hold the accepted word in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_word;
		end
	end

	// Advance the decided word into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid_s1) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Failure count never passes its cap
	a_fail_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.failure_count <= FAIL_CAP))
		else $error("failure count above cap");

	// Only a poll yields an action
	a_none_non_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && advance && (item_s1.operation != OP_POLL))
		|=> (out_word.action == ACT_NONE))
		else $error("action on a non-poll event");

	// An open event reports an open session with a cleared count
	a_open_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && advance && (item_s1.operation == OP_OPENED))
		|=> (out_word.session_open && (out_word.failure_count == '0)))
		else $error("open event result wrong");

	// Output stage fills only from a valid input stage
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(item_valid_s1))
		else $error("output word without input stage word");

endmodule

// ===== rtl/sbrp_cfg.sv =====
// Configuration register file with the backoff reload strobe.
`timescale 1ns / 1ps

module sbrp_cfg import sbrp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  cfg_idx_t            wr_index,
	input  logic [CFG_BITS-1:0] wr_data,
	output cfg_t                cfg,
	output bo_load_t            bo_load
);

	cfg_t cfg_q;

	// Write one register per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_MAX_SESSION_TIME: cfg_q.max_session_time <= wr_data;
				CFG_RENEW_MARGIN:     cfg_q.renew_margin     <= wr_data;
				CFG_BACKOFF_START:    cfg_q.backoff_start    <= wr_data;
				CFG_BACKOFF_LIMIT:    cfg_q.backoff_limit    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// A new starting backoff also reloads the running backoff
	assign bo_load.load  = wr_en && (wr_index == CFG_BACKOFF_START);
	assign bo_load.value = wr_data;

endmodule

// ===== rtl/sbrp_policy.sv =====
// Session state registers and the per-event decision logic.
`timescale 1ns / 1ps

module sbrp_policy import sbrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  bo_load_t  bo_load,
	input  logic      fire,
	input  in_word_t  item,
	output out_word_t result
);

	logic                 is_open_q, is_open_d;
	logic [TIME_BITS-1:0] open_time_q, open_time_d;
	logic [TIME_BITS-1:0] retry_time_q, retry_time_d;
	logic [CFG_BITS-1:0]  backoff_q, backoff_d;
	logic [FAIL_BITS-1:0] fail_count_q, fail_count_d;
	action_t              action;

	logic [CFG_BITS:0]    bo_grown;
	logic [CFG_BITS:0]    bo_limit_ext;
	logic [CFG_BITS-1:0]  margin;
	logic [CFG_BITS-1:0]  span;
	logic [TIME_BITS-1:0] renew_time;
	logic                 renew_due;

	// Doubled backoff, or the start value when the backoff is zero
	always_comb begin
		bo_limit_ext = {1'b0, cfg.backoff_limit};
		if (backoff_q != '0) begin
			bo_grown = {backoff_q, 1'b0};
		end else begin
			bo_grown = {1'b0, cfg.backoff_start};
		end
	end

	// Renewal deadline: open time plus lifetime less the margin
	always_comb begin
		margin = (cfg.renew_margin >= cfg.max_session_time) ?
			(cfg.max_session_time >> 1) : cfg.renew_margin;
		span       = cfg.max_session_time - margin;
		renew_time = time_add_sat(open_time_q, span);
		renew_due  = (cfg.max_session_time != '0) && (item.now_time >= renew_time);
	end

	// Next state and action for the event at hand
	always_comb begin
		is_open_d    = is_open_q;
		open_time_d  = open_time_q;
		retry_time_d = retry_time_q;
		backoff_d    = backoff_q;
		fail_count_d = fail_count_q;
		action       = ACT_NONE;
		case (item.operation)
			OP_OPENED: begin
				is_open_d    = 1'b1;
				open_time_d  = item.now_time;
				retry_time_d = item.now_time;
				backoff_d    = cfg.backoff_start;
				fail_count_d = '0;
			end
			OP_CLOSED: begin
				is_open_d = 1'b0;
				if (!item.close_failed) begin
					retry_time_d = item.now_time;
					backoff_d    = cfg.backoff_start;
					fail_count_d = '0;
				end else begin
					retry_time_d = time_add_sat(item.now_time, backoff_q);
					if (fail_count_q < FAIL_CAP) begin
						fail_count_d = fail_count_q + FAIL_BITS'(1);
					end
					backoff_d = (bo_grown > bo_limit_ext) ?
						cfg.backoff_limit : bo_grown[CFG_BITS-1:0];
				end
			end
			OP_POLL: begin
				if (!is_open_q) begin
					action = (item.link_up && (item.now_time >= retry_time_q)) ?
						ACT_CONNECT : ACT_WAIT;
				end else if (item.request_busy) begin
					action = ACT_KEEP;
				end else begin
					action = (!item.link_up || renew_due) ? ACT_RENEW : ACT_KEEP;
				end
			end
			default: ;
		endcase
	end

	assign result.action        = action;
	assign result.failure_count = fail_count_d;
	assign result.session_open  = is_open_d;

	// Commit the event, or reload the backoff on a configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_open_q    <= 1'b0;
			open_time_q  <= '0;
			retry_time_q <= '0;
			backoff_q    <= '0;
			fail_count_q <= '0;
		end else if (bo_load.load) begin
			backoff_q <= bo_load.value;
		end else if (fire) begin
			is_open_q    <= is_open_d;
			open_time_q  <= open_time_d;
			retry_time_q <= retry_time_d;
			backoff_q    <= backoff_d;
			fail_count_q <= fail_count_d;
		end
	end

endmodule

// ===== bench/session_backoff_renew_policy_top_tb.sv =====
// Self-checking bench for the session backoff and renewal policy block.
`timescale 1ns / 1ps

module session_backoff_renew_policy_top_tb;
	import sbrp_pkg::*;

	localparam logic [TIME_BITS-1:0] TOP_TIME = '1;
	localparam op_t OP_SPARE = op_t'(2'b11);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = CFG_MAX_SESSION_TIME;
	logic [CFG_BITS-1:0] cfg_data = '0;

	session_backoff_renew_policy_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Policy registers and session state as the block should hold them
	logic [CFG_BITS-1:0]  pol_life = '0;
	logic [CFG_BITS-1:0]  pol_margin = '0;
	logic [CFG_BITS-1:0]  pol_bo_start = '0;
	logic [CFG_BITS-1:0]  pol_bo_limit = '0;
	logic                 sess_open = 1'b0;
	logic [TIME_BITS-1:0] sess_open_at = '0;
	logic [TIME_BITS-1:0] sess_retry_at = '0;
	logic [CFG_BITS-1:0]  sess_backoff = '0;
	logic [FAIL_BITS-1:0] sess_fails = '0;

	in_word_t  pending_events[$];
	out_word_t answers_owed[$];
	out_word_t owed;
	int unsigned events_queued = 0;
	int unsigned fault_count = 0;
	int unsigned idle_odds = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	logic in_fire = 1'b0;
	logic [TIME_BITS-1:0] stamp = '0;

	function automatic logic [TIME_BITS-1:0] clamp_add(logic [TIME_BITS-1:0] base,
			logic [CFG_BITS-1:0] span);
		logic [TIME_BITS:0] total;
		total = {1'b0, base} + (TIME_BITS + 1)'(span);
		return total[TIME_BITS] ? TOP_TIME : total[TIME_BITS-1:0];
	endfunction

	// Apply one event to the session state and return the answer it should produce
	function automatic out_word_t policy_answer(in_word_t ev);
		out_word_t r;
		logic [CFG_BITS:0]    doubled;
		logic [CFG_BITS-1:0]  margin_ms;
		logic [TIME_BITS-1:0] renew_deadline;
		logic                 due;
		r.action = ACT_NONE;
		case (ev.operation)
		OP_OPENED: begin
			sess_open = 1'b1;
			sess_open_at = ev.now_time;
			sess_retry_at = ev.now_time;
			sess_backoff = pol_bo_start;
			sess_fails = '0;
		end
		OP_CLOSED: begin
			sess_open = 1'b0;
			if (!ev.close_failed) begin
				sess_backoff = pol_bo_start;
				sess_retry_at = ev.now_time;
				sess_fails = '0;
			end else begin
				sess_retry_at = clamp_add(ev.now_time, sess_backoff);
				if (sess_fails < FAIL_CAP)
					sess_fails = sess_fails + 1'b1;
				// double the backoff, or take the start value when it is zero, then clamp
				doubled = (sess_backoff != '0) ? {sess_backoff, 1'b0} : {1'b0, pol_bo_start};
				sess_backoff = (doubled > {1'b0, pol_bo_limit}) ? pol_bo_limit
					: doubled[CFG_BITS-1:0];
			end
		end
		OP_POLL: begin
			if (!sess_open) begin
				r.action = (ev.link_up && ev.now_time >= sess_retry_at) ? ACT_CONNECT : ACT_WAIT;
			end else if (ev.request_busy) begin
				r.action = ACT_KEEP;
			end else begin
				due = 1'b0;
				// a zero lifetime never renews by time
				if (pol_life != '0) begin
					margin_ms = (pol_margin >= pol_life) ? (pol_life >> 1) : pol_margin;
					renew_deadline = clamp_add(sess_open_at, pol_life - margin_ms);
					due = ev.now_time >= renew_deadline;
				end
				r.action = (!ev.link_up || due) ? ACT_RENEW : ACT_KEEP;
			end
		end
		default: ;
		endcase
		r.failure_count = sess_fails;
		r.session_open = sess_open;
		return r;
	endfunction

	task automatic report_fault(string msg);
		fault_count++;
		if (fault_count <= 100)
			$display("%0t ns: %s", $time, msg);
	endtask

	function automatic bit chance(int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic queue_event(op_t op, logic [TIME_BITS-1:0] at, bit failed, bit busy,
			bit link);
		in_word_t ev;
		ev.operation = op;
		ev.now_time = at;
		ev.close_failed = failed;
		ev.request_busy = busy;
		ev.link_up = link;
		pending_events.push_back(ev);
		events_queued++;
	endtask

	task automatic tick(int unsigned step_max);
		stamp = clamp_add(stamp, CFG_BITS'($urandom_range(0, step_max)));
	endtask

	// Mostly whole sessions with random timing, the rest arbitrary words
	task automatic add_traffic(int unsigned count, int unsigned step_max);
		int unsigned target;
		target = events_queued + count;
		while (events_queued < target) begin
			if (chance(80)) begin
				tick(step_max);
				queue_event(OP_OPENED, stamp, chance(50), chance(50), chance(50));
				repeat ($urandom_range(1, 6)) begin
					tick(step_max);
					queue_event(OP_POLL, stamp, chance(50), chance(30), chance(85));
				end
				tick(step_max);
				queue_event(OP_CLOSED, stamp, chance(60), chance(50), chance(50));
				repeat ($urandom_range(0, 4)) begin
					tick(step_max);
					if (chance(25))
						queue_event(OP_CLOSED, stamp, 1'b1, chance(50), chance(50));
					queue_event(OP_POLL, stamp, chance(50), chance(50), chance(80));
				end
			end else begin
				queue_event(op_t'(2'($urandom_range(0, 3))),
					chance(35) ? TIME_BITS'({$urandom, $urandom}) : stamp,
					chance(50), chance(50), chance(50));
			end
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write the registers selected by mask, bit i for register index i
	task automatic set_policy(logic [3:0] mask, logic [CFG_BITS-1:0] life,
			logic [CFG_BITS-1:0] margin, logic [CFG_BITS-1:0] start,
			logic [CFG_BITS-1:0] limit);
		if (mask[CFG_MAX_SESSION_TIME]) write_reg(CFG_MAX_SESSION_TIME, life);
		if (mask[CFG_RENEW_MARGIN])     write_reg(CFG_RENEW_MARGIN, margin);
		if (mask[CFG_BACKOFF_START])    write_reg(CFG_BACKOFF_START, start);
		if (mask[CFG_BACKOFF_LIMIT])    write_reg(CFG_BACKOFF_LIMIT, limit);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_events.size() != 0 || in_valid || answers_owed.size() != 0);
	endtask

	task automatic run_phase(logic [3:0] mask, logic [CFG_BITS-1:0] life,
			logic [CFG_BITS-1:0] margin, logic [CFG_BITS-1:0] start,
			logic [CFG_BITS-1:0] limit, int unsigned odds, int unsigned count,
			int unsigned step_max);
		set_policy(mask, life, margin, start, limit);
		idle_odds = odds;
		stamp = TIME_BITS'($urandom_range(0, 1000000));
		add_traffic(count, step_max);
	endtask

	// Drive event words, with random bursts of idle cycles between them
	always @(negedge clk) begin
		if (in_valid && !in_fire) begin
			// hold the word until it is taken
		end else if (gap_left != 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pending_events.size() == 0) begin
			in_valid <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			gap_left = $urandom_range(1, 7) - 1;
			in_valid <= 1'b0;
		end else begin
			in_word <= pending_events.pop_front();
			in_valid <= 1'b1;
		end
	end

	// Stall the result side in bursts
	always @(negedge clk) begin
		if (stall_left != 0)
			stall_left--;
		else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
			stall_left = $urandom_range(1, 7);
		out_ready <= (stall_left == 0);
	end

	// Track register writes and taken words, check each result word
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_MAX_SESSION_TIME: pol_life = cfg_data;
				CFG_RENEW_MARGIN:     pol_margin = cfg_data;
				CFG_BACKOFF_START: begin
					pol_bo_start = cfg_data;
					sess_backoff = cfg_data;
				end
				CFG_BACKOFF_LIMIT:    pol_bo_limit = cfg_data;
				default: ;
				endcase
			end
			if (in_fire)
				answers_owed.push_back(policy_answer(in_word));
			if (out_valid && out_ready) begin
				if (answers_owed.size() == 0) begin
					report_fault($sformatf("result word %p with nothing expected", out_word));
				end else begin
					owed = answers_owed.pop_front();
					if (out_word.action !== owed.action)
						report_fault($sformatf("action got %0d want %0d",
							out_word.action, owed.action));
					if (out_word.failure_count !== owed.failure_count)
						report_fault($sformatf("failure_count got %0d want %0d",
							out_word.failure_count, owed.failure_count));
					if (out_word.session_open !== owed.session_open)
						report_fault($sformatf("session_open got %0b want %0b",
							out_word.session_open, owed.session_open));
				end
			end
		end
	end

	initial begin
		logic [CFG_BITS-1:0] life;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: no lifetime limit, zero backoff
		idle_odds = 3;
		add_traffic(30, 50);
		wait_idle();

		set_policy(4'hF, 1000, 200, 10, 40);
		// poll while closed, with and without link
		queue_event(OP_POLL, 0, 1'b0, 1'b0, 1'b0);
		queue_event(OP_POLL, 0, 1'b0, 1'b0, 1'b1);
		// open, then busy, link down, just before and at the renew time
		queue_event(OP_OPENED, 100, 1'b0, 1'b0, 1'b0);
		queue_event(OP_POLL, 150, 1'b0, 1'b1, 1'b0);
		queue_event(OP_POLL, 150, 1'b0, 1'b0, 1'b0);
		queue_event(OP_POLL, 899, 1'b0, 1'b0, 1'b1);
		queue_event(OP_POLL, 900, 1'b0, 1'b0, 1'b1);
		// failed close, retry window edges, backoff reaching its limit
		queue_event(OP_CLOSED, 1000, 1'b1, 1'b0, 1'b0);
		queue_event(OP_POLL, 1009, 1'b0, 1'b0, 1'b1);
		queue_event(OP_POLL, 1010, 1'b0, 1'b0, 1'b1);
		queue_event(OP_CLOSED, 1020, 1'b1, 1'b1, 1'b1);
		queue_event(OP_CLOSED, 1030, 1'b1, 1'b0, 1'b0);
		queue_event(OP_POLL, 5000, 1'b0, 1'b1, 1'b0);
		// clean close clears the failure count
		queue_event(OP_CLOSED, 6000, 1'b0, 1'b1, 1'b1);
		// unused operation code changes nothing
		queue_event(OP_SPARE, TOP_TIME, 1'b1, 1'b1, 1'b1);
		// timestamps at the top of the range saturate the sums
		queue_event(OP_OPENED, TOP_TIME, 1'b1, 1'b1, 1'b1);
		queue_event(OP_POLL, TOP_TIME, 1'b1, 1'b0, 1'b1);
		queue_event(OP_CLOSED, TOP_TIME, 1'b1, 1'b0, 1'b0);
		queue_event(OP_POLL, TOP_TIME, 1'b0, 1'b0, 1'b1);
		queue_event(OP_POLL, 0, 1'b0, 1'b1, 1'b1);
		add_traffic(40, 300);
		wait_idle();

		// margin equal to lifetime falls back to half the lifetime
		run_phase(4'hF, 1000, 1000, 7, 1000, 2, 30, 400);
		wait_idle();

		// one-millisecond lifetime with an oversized margin, no idling
		run_phase(4'b0011, 1, 32'hFFFF_FFFF, 0, 0, 0, 25, 3);
		wait_idle();

		// extremes: backoff doubles up to the full range, failure count saturates
		set_policy(4'hF, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF);
		idle_odds = 6;
		stamp = TOP_TIME - 48'h3_0000_0000;
		queue_event(OP_OPENED, stamp, 1'b0, 1'b0, 1'b0);
		repeat (1010) begin
			tick(1 << 28);
			if (chance(5))
				queue_event(OP_POLL, stamp, chance(50), chance(50), chance(80));
			queue_event(OP_CLOSED, stamp, 1'b1, chance(50), chance(50));
		end
		queue_event(OP_POLL, stamp, 1'b0, 1'b0, 1'b1);
		queue_event(OP_CLOSED, stamp, 1'b0, 1'b0, 1'b0);
		add_traffic(20, 1 << 30);
		wait_idle();

		// zero limit drives the backoff to zero
		run_phase(4'b1100, 0, 0, 300, 0, 4, 20, 100);
		queue_event(OP_CLOSED, stamp, 1'b1, 1'b0, 1'b0);
		queue_event(OP_CLOSED, stamp, 1'b1, 1'b0, 1'b0);
		wait_idle();

		// raise the limit alone: a zero backoff restarts from the start value
		set_policy(4'b1000, 0, 0, 0, 500);
		idle_odds = 20;
		queue_event(OP_CLOSED, stamp, 1'b1, 1'b0, 1'b0);
		queue_event(OP_CLOSED, stamp, 1'b1, 1'b0, 1'b0);
		add_traffic(20, 500);
		wait_idle();

		// random policy
		life = $urandom_range(0, 200000);
		run_phase(4'hF, life, chance(40) ? $urandom : (life >> $urandom_range(1, 8)),
			$urandom_range(0, 5000), chance(20) ? $urandom : $urandom_range(0, 100000),
			3, 30, $urandom_range(1, 100000));
		wait_idle();

		// closing stretch with no idling on either side
		run_phase(4'hF, 60000, 5000, 100, 6400, 0, 80, 3000);
		wait_idle();

		repeat (10) @(posedge clk);
		if (answers_owed.size() != 0)
			report_fault($sformatf("%0d result words never arrived", answers_owed.size()));
		if (fault_count == 0)
			$display("session_backoff_renew_policy_top_tb OK");
		else
			$display("session_backoff_renew_policy_top_tb NOT OK");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("session_backoff_renew_policy_top_tb NOT OK");
		$finish;
	end

endmodule
